@@ sv/multirotor_motor_mixer_assert.svh @@
// ----------------------------------------------------------------------------
// mixer assertion macros
// shared property wrappers for the mixer modules
// ----------------------------------------------------------------------------
`ifndef MULTIROTOR_MOTOR_MIXER_ASSERT_SVH
`define MULTIROTOR_MOTOR_MIXER_ASSERT_SVH

// implication checked on every clock, off during reset
`define MM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer check failed");

// next-cycle implication
`define MM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer check failed");

`endif

@@ sv/mmix_pkg.sv @@
// ----------------------------------------------------------------------------
// mixer package
// shared types and constants for the motor mixer
// ----------------------------------------------------------------------------
package mmix_pkg;

    localparam int ONE_Q14 = 16384;
    localparam int NUM_REGS = 5;

    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_GEO0  = 3'd1;
    localparam logic [2:0] REG_GEO3  = 3'd4;

    typedef struct packed {
        logic signed [15:0] thrust_cmd;
        logic signed [15:0] pitch_cmd;
        logic signed [15:0] roll_cmd;
        logic signed [15:0] yaw_cmd;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         motor_index;
        logic signed [15:0] drive_level;
        logic               last_motor;
    } t_drive;

    typedef struct packed {
        logic signed [15:0] py;
        logic signed [15:0] rx;
        logic               ccw;
    } t_coef;

    typedef enum logic [2:0] {
        S_CLEAR, S_MAX, S_DIV, S_IDLE, S_RUN
    } t_state;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [14:0] num;
        logic [14:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [15:0] quo;
    } t_div_rsp;

endpackage

@@ sv/mmix_div.sv @@
// ----------------------------------------------------------------------------
// coefficient divider
// restoring divider giving round(num*16384/den), one quotient bit per cycle
// ----------------------------------------------------------------------------
module mmix_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmix_pkg::t_div_req   i_req,
    output mmix_pkg::t_div_rsp   o_rsp
);
    logic [16:0] r_rem, n_rem;
    logic [16:0] r_quo;
    logic [14:0] r_den;
    logic [29:0] r_num;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_trial;

    // quotient of (2*num*16384 + den) / den, 17 bits, then halve
    always_comb begin
        w_trial = {r_rem, r_num[29]};
        n_rem   = w_trial[16:0];
        if (w_trial >= {3'b0, r_den}) begin
            n_rem = 17'(w_trial - {3'b0, r_den});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= 17'd0;
                r_den  <= i_req.den;
                // 2*num*16384 + den, fits 30 bits; top bit fed first
                r_num  <= {i_req.num, 15'd0} + {15'd0, i_req.den};
                r_quo  <= 17'd0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[28:0], 1'b0};
                r_quo <= {r_quo[15:0], (w_trial >= {3'b0, r_den})};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd29) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo[16:1];

    `include "multirotor_motor_mixer_assert.svh"
    `MM_ASSERT_NXT(a_div_done, i_clk, i_rst_n, r_busy && r_cnt == 5'd29 && !i_req.start, r_done)
    `MM_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_done, !r_busy)
    `MM_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, r_busy, r_cnt <= 5'd29)
endmodule

@@ sv/multirotor_motor_mixer.sv @@
// an accepted request is registered, each coefficient is read into r_rd, then the
// drive level is registered in r_out; one drive level per cycle while i_stall is low
// a new request is taken only once the last is issued; a register write rebuilds the table
// reset: motor_count 4, zero geometry; table rebuilt before the first request
// the coefficient table sits in one MAX_MOTORS-entry (default 8) synchronous memory
module multirotor_motor_mixer #(
    parameter int MAX_MOTORS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mmix_pkg::t_cmd      i_cmd,
    output logic                o_valid,
    input  logic                i_stall,
    output mmix_pkg::t_drive    o_drive,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    localparam int MW = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;

    logic [3:0]      r_count;
    logic [63:0]     r_geo [4];
    mmix_pkg::t_state r_state, n_state;
    logic [3:0]      r_i;
    logic [14:0]     r_mx, r_my;
    logic            r_axis;      // 0 rx, 1 py
    logic            r_divwait;
    logic signed [15:0] r_rx;
    mmix_pkg::t_coef r_mem [MAX_MOTORS];
    mmix_pkg::t_coef r_rd;
    mmix_pkg::t_cmd  r_cmd;
    logic            r_rd_v;
    logic [3:0]      r_rd_i;
    logic            r_ov;
    mmix_pkg::t_drive r_out;
    logic [3:0]      w_n;
    logic [MW-1:0]   w_ra;
    logic [2:0]      w_reg;
    logic            w_wr;
    logic [31:0]     w_word;
    logic signed [14:0] w_x, w_y, w_v;
    logic [14:0]     w_ax, w_ay;
    mmix_pkg::t_div_req w_dreq;
    mmix_pkg::t_div_rsp w_drsp;
    logic signed [47:0] w_acc;
    logic signed [31:0] w_p, w_r;
    logic signed [16:0] w_yaw;
    logic signed [15:0] w_drv;
    logic            w_adv;

    assign pready = 1'b1;
    assign w_reg  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite;
    always_comb begin
        prdata = 64'd0;
        if (w_reg == mmix_pkg::REG_COUNT) prdata = {60'd0, r_count};
        else if (w_reg >= mmix_pkg::REG_GEO0 && w_reg <= mmix_pkg::REG_GEO3)
            prdata = r_geo[2'(w_reg - mmix_pkg::REG_GEO0)];
    end

    always_comb begin
        w_n = r_count;
        if (w_n == 4'd0) w_n = 4'd1;
        if (32'(w_n) > MAX_MOTORS) w_n = 4'(MAX_MOTORS);
    end

    assign w_word = r_i[0] ? r_geo[r_i[2:1]][63:32] : r_geo[r_i[2:1]][31:0];
    assign w_x  = w_word[14:0];
    assign w_y  = w_word[29:15];
    assign w_ax = w_x[14] ? 15'(-w_x) : w_x;
    assign w_ay = w_y[14] ? 15'(-w_y) : w_y;
    assign w_v  = r_axis ? w_y : w_x;

    assign w_dreq.start = (r_state == mmix_pkg::S_DIV) && !r_divwait;
    assign w_dreq.num   = r_axis ? w_ay : w_ax;
    assign w_dreq.den   = r_axis ? r_my : r_mx;

    mmix_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    assign w_adv = !r_ov || !i_stall;
    assign o_stall = !(r_state == mmix_pkg::S_IDLE) || w_wr || (r_rd_v && !w_adv);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mmix_pkg::S_CLEAR: n_state = mmix_pkg::S_MAX;
            mmix_pkg::S_MAX:   if (r_i == w_n - 4'd1) n_state = mmix_pkg::S_DIV;
            mmix_pkg::S_DIV:   if (r_i == w_n - 4'd1 && r_axis && r_divwait &&
                                   (w_drsp.done || r_my == 15'd0))
                                   n_state = mmix_pkg::S_IDLE;
            mmix_pkg::S_IDLE:  if (i_valid && !o_stall) n_state = mmix_pkg::S_RUN;
            mmix_pkg::S_RUN:   if (r_i == w_n - 4'd1 && w_adv) n_state = mmix_pkg::S_IDLE;
            default:           n_state = mmix_pkg::S_CLEAR;
        endcase
        if (w_wr) n_state = mmix_pkg::S_CLEAR;
    end

    assign w_ra = (r_state == mmix_pkg::S_IDLE) ? '0 : MW'(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mmix_pkg::S_CLEAR;
            r_count   <= 4'd4;
            for (int k = 0; k < 4; k++) r_geo[k] <= 64'd0;
            r_i       <= 4'd0;
            r_divwait <= 1'b0;
            r_axis    <= 1'b0;
            r_rd_v    <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                if (w_reg == mmix_pkg::REG_COUNT) r_count <= pwdata[3:0];
                else if (w_reg >= mmix_pkg::REG_GEO0 && w_reg <= mmix_pkg::REG_GEO3)
                    r_geo[2'(w_reg - mmix_pkg::REG_GEO0)] <= pwdata;
            end
            case (r_state)
                mmix_pkg::S_CLEAR: begin
                    r_i <= 4'd0; r_mx <= 15'd0; r_my <= 15'd0;
                    r_axis <= 1'b0; r_divwait <= 1'b0;
                end
                mmix_pkg::S_MAX: begin
                    if (w_ax > r_mx) r_mx <= w_ax;
                    if (w_ay > r_my) r_my <= w_ay;
                    r_i <= (r_i == w_n - 4'd1) ? 4'd0 : r_i + 4'd1;
                end
                mmix_pkg::S_DIV: begin
                    if (!r_divwait) r_divwait <= 1'b1;
                    else if (w_drsp.done || (r_axis ? r_my : r_mx) == 15'd0) begin
                        r_divwait <= 1'b0;
                        if (!r_axis) begin
                            r_rx   <= (r_mx == 15'd0) ? 16'sd0 :
                                      (w_v[14] ? 16'(-w_drsp.quo) : w_drsp.quo);
                            r_axis <= 1'b1;
                        end else begin
                            r_mem[MW'(r_i)] <= '{py: (r_my == 15'd0) ? 16'sd0 :
                                              (w_v[14] ? 16'(-w_drsp.quo) : w_drsp.quo),
                                              rx: r_rx, ccw: w_word[30]};
                            r_axis <= 1'b0;
                            r_i    <= (r_i == w_n - 4'd1) ? 4'd0 : r_i + 4'd1;
                        end
                    end
                end
                mmix_pkg::S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_cmd <= i_cmd;
                        r_i   <= 4'd0;
                    end
                end
                mmix_pkg::S_RUN: begin
                    if (w_adv) r_i <= (r_i == w_n - 4'd1) ? 4'd0 : r_i + 4'd1;
                end
                default: ;
            endcase
            // memory read, registered into r_rd
            if (w_adv || (r_state != mmix_pkg::S_RUN && !r_rd_v)) begin
                r_rd   <= r_mem[w_ra];
                r_rd_i <= r_i;
                r_rd_v <= (r_state == mmix_pkg::S_RUN);
            end
            if (w_adv) begin
                r_ov <= r_rd_v;
                if (r_rd_v) r_out <= '{motor_index: 3'(r_rd_i), drive_level: w_drv,
                                       last_motor: (r_rd_i == w_n - 4'd1)};
            end
        end
    end

    // drive computation from registered coefficient
    assign w_p   = r_cmd.pitch_cmd * r_rd.py;
    assign w_r   = r_cmd.roll_cmd * r_rd.rx;
    assign w_yaw = r_rd.ccw ? -17'(r_cmd.yaw_cmd) : 17'(r_cmd.yaw_cmd);
    assign w_acc = ((48'(r_cmd.thrust_cmd) + 48'(w_yaw)) <<< 14) + 48'(w_p) + 48'(w_r);
    always_comb begin
        if (w_acc >= 48'sd268435456) w_drv = 16'sd16384;
        else if (w_acc <= -48'sd268435456) w_drv = -16'sd16384;
        else w_drv = 16'((w_acc + 48'sd8192) >>> 14);
    end

    assign o_valid = r_ov;
    assign o_drive = r_out;

    `include "multirotor_motor_mixer_assert.svh"
    `MM_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n,
                   r_state != mmix_pkg::S_IDLE, o_stall)
    `MM_ASSERT_IMP(a_idx_range, i_clk, i_rst_n,
                   r_state == mmix_pkg::S_RUN, r_i < w_n)
    `MM_ASSERT_IMP(a_last_idx, i_clk, i_rst_n,
                   o_valid && o_drive.last_motor, 4'(o_drive.motor_index) == w_n - 4'd1)
endmodule

@@ bench/multirotor_motor_mixer_tb.sv @@
// ----------------------------------------------------------------------------
// motor mixer testbench
// Drives thrust/pitch/roll/yaw requests through the mixer under several motor
// geometries written over the register port. A behavioral mixer model predicts
// each drive; directed rows give their own level. Outputs are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multirotor_motor_mixer_tb;

    localparam logic [2:0] REG_NONE = mmix_pkg::REG_GEO3 + 3'd1;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE = 20;

    typedef struct {
        mmix_pkg::t_cmd     cmd;
        bit                 typed;
        logic signed [15:0] lvl;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    mmix_pkg::t_cmd   i_cmd = '0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    mmix_pkg::t_drive o_drive;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // model registers
    logic [3:0]  mdl_count;
    logic [63:0] mdl_geo [4];

    mmix_pkg::t_drive drive_q [$];
    bit          typed_cur = 1'b0;
    logic signed [15:0] typed_lvl = '0;
    int          err_cnt = 0;
    int          quiet_cycles = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    multirotor_motor_mixer dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int scale_coef(int v, int m);
        longint num, q;
        if (m == 0) return 0;
        num = longint'(v < 0 ? -v : v) * 16384;
        q = (num + m / 2) / m;
        return v < 0 ? -int'(q) : int'(q);
    endfunction

    function automatic void predict_drives(mmix_pkg::t_cmd c, bit typed,
                                           logic signed [15:0] lvl);
        int n, mx, my, x, y, rx, py, yaw;
        logic [31:0] w;
        longint acc;
        mmix_pkg::t_drive d;
        n = mdl_count;
        if (n == 0) n = 1;
        if (n > 8) n = 8;
        mx = 0;
        my = 0;
        for (int i = 0; i < n; i++) begin
            w = mdl_geo[i >> 1][(i & 1) * 32 +: 32];
            x = $signed(w[14:0]);
            y = $signed(w[29:15]);
            if (x < 0) x = -x;
            if (y < 0) y = -y;
            if (x > mx) mx = x;
            if (y > my) my = y;
        end
        for (int i = 0; i < n; i++) begin
            w = mdl_geo[i >> 1][(i & 1) * 32 +: 32];
            rx = scale_coef($signed(w[14:0]), mx);
            py = scale_coef($signed(w[29:15]), my);
            yaw = w[30] ? -int'(c.yaw_cmd) : int'(c.yaw_cmd);
            acc = longint'(c.thrust_cmd) * 16384 + longint'(c.pitch_cmd) * py
                + longint'(c.roll_cmd) * rx + longint'(yaw) * 16384;
            d.motor_index = i[2:0];
            d.last_motor = (i == n - 1);
            if (typed)
                d.drive_level = lvl;
            else if (acc >= 64'sd268435456)
                d.drive_level = 16'sd16384;
            else if (acc <= -64'sd268435456)
                d.drive_level = -16'sd16384;
            else
                d.drive_level = 16'(((acc + 64'sd268435456 + 8192) >>> 14) - 16384);
            drive_q.push_back(d);
        end
    endfunction

    // request and drive monitors, watchdog
    always @(posedge i_clk) begin
        mmix_pkg::t_drive e;
        bit seen;
        if (i_rst_n) begin
            seen = psel;
            if (i_valid && !o_stall) begin
                seen = 1'b1;
                predict_drives(i_cmd, typed_cur, typed_lvl);
            end
            if (o_valid && !i_stall) begin
                seen = 1'b1;
                if (drive_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected drive: motor %0d level %0d last %0b",
                                 o_drive.motor_index, o_drive.drive_level,
                                 o_drive.last_motor);
                end else begin
                    e = drive_q.pop_front();
                    if (o_drive !== e) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"mismatch: exp motor %0d level %0d last %0b, ",
                                      "got motor %0d level %0d last %0b"},
                                     e.motor_index, e.drive_level, e.last_motor,
                                     o_drive.motor_index, o_drive.drive_level,
                                     o_drive.last_motor);
                    end
                end
            end
            quiet_cycles <= seen ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // drive level receiver
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            w = idle_on ? $urandom_range(0, 14) : 0;
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_cmd(mmix_pkg::t_cmd c, bit typed, logic signed [15:0] lvl);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= c;
        typed_cur <= typed;
        typed_lvl <= lvl;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == mmix_pkg::REG_COUNT)
            mdl_count = val[3:0];
        else if (idx >= mmix_pkg::REG_GEO0 && idx <= mmix_pkg::REG_GEO3)
            mdl_geo[idx - mmix_pkg::REG_GEO0] = val;
    endtask

    function automatic logic [14:0] pick_coord(bit hard);
        case ($urandom_range(0, hard ? 4 : 6))
            0: return 15'h4000;
            1: return 15'h3FFF;
            2: return 15'h0000;
            3: return 15'h0001;
            4: return 15'h7FFF;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] gen_motor(bit hard, bit zero_x);
        logic [14:0] x;
        x = zero_x ? 15'h0 : pick_coord(hard);
        return {1'($urandom), 1'($urandom), pick_coord(hard), x};
    endfunction

    function automatic logic signed [15:0] gen_field();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh4000;
            3: return -16'sh4000;
            4, 5: return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    t_row dir_rows [13] = '{
        '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd16384},
        '{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b1, -16'sd16384},
        '{'{16'sh7FFF, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd16384},
        '{'{16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b1, -16'sd16384},
        '{'{16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0}, 1'b1, 16'sd0},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 16'sd0},
        '{'{16'sd8192, 16'sd0, 16'sd0, 16'sd8191}, 1'b1, 16'sd16383},
        '{'{-16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b1, -16'sd1},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sh8000}, 1'b1, -16'sd16384},
        '{'{16'sd16383, 16'sd0, 16'sd0, 16'sd1}, 1'b1, 16'sd16384},
        '{'{16'sd100, 16'sh8000, 16'sh7FFF, 16'sd200}, 1'b1, 16'sd300},
        '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 1'b0, 16'sd0},
        '{'{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA}, 1'b0, 16'sd0}
    };

    initial begin
        logic [3:0]  cnt;
        logic [63:0] g;
        mmix_pkg::t_cmd c;
        mdl_count = 4'd4;
        foreach (mdl_geo[k]) mdl_geo[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            send_cmd(dir_rows[r].cmd, dir_rows[r].typed, dir_rows[r].lvl);

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            case (ph)
                0: cnt = 4'd8;
                1: cnt = 4'd0;
                2: cnt = 4'd15;
                3: cnt = 4'd1;
                4: cnt = 4'd3;
                5: cnt = 4'd8;
                default: cnt = 4'($urandom_range(0, 15));
            endcase
            reg_write(mmix_pkg::REG_COUNT, {60'($urandom), cnt});
            for (int p = 0; p < 4; p++) begin
                g = {gen_motor(ph < 2, ph == 5), gen_motor(ph < 2, ph == 5)};
                reg_write(mmix_pkg::REG_GEO0 + 3'(p), g);
            end
            if (ph == 4) reg_write(REG_NONE, {$urandom, $urandom});
            idle_on = (ph % 3 != 1);
            if (ph == 2) hold_req = 1'b1;
            for (int k = 0; k < 50; k++) begin
                if (ph == 6 && k == 25) drain();
                c.thrust_cmd = gen_field();
                c.pitch_cmd = gen_field();
                c.roll_cmd = gen_field();
                c.yaw_cmd = gen_field();
                send_cmd(c, 1'b0, '0);
            end
        end
        drain();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
